// File: hdl/dsfr_pkg.sv
package dsfr_pkg;

    // fixed field widths
    localparam int BYTE_W  = 8;
    localparam int POS_W   = 6;
    localparam int LEN_W   = 7;
    localparam int DATA_W  = 32;

    // register file addressing
    localparam int REG_IDX_W = 3;
    localparam int PADDR_W   = REG_IDX_W + 2;

    typedef logic [REG_IDX_W-1:0] reg_idx_t;

    localparam reg_idx_t REG_HDR1    = 3'd0;
    localparam reg_idx_t REG_HDR2    = 3'd1;
    localparam reg_idx_t REG_HDR3    = 3'd2;
    localparam reg_idx_t REG_TRL1    = 3'd3;
    localparam reg_idx_t REG_TRL2    = 3'd4;
    localparam reg_idx_t REG_MAX_LEN = 3'd5;

    // register reset values
    localparam logic [BYTE_W-1:0] HDR1_RST    = 8'd170;
    localparam logic [BYTE_W-1:0] HDR2_RST    = 8'd85;
    localparam logic [BYTE_W-1:0] HDR3_RST    = 8'd165;
    localparam logic [BYTE_W-1:0] TRL1_RST    = 8'd13;
    localparam logic [BYTE_W-1:0] TRL2_RST    = 8'd10;
    localparam logic [LEN_W-1:0]  MAX_LEN_RST = 7'd64;

    // line terminators
    localparam logic [BYTE_W-1:0] CR_BYTE = 8'h0D;
    localparam logic [BYTE_W-1:0] LF_BYTE = 8'h0A;

    typedef struct packed {
        logic [BYTE_W-1:0] hdr1;
        logic [BYTE_W-1:0] hdr2;
        logic [BYTE_W-1:0] hdr3;
        logic [BYTE_W-1:0] trl1;
        logic [BYTE_W-1:0] trl2;
        logic [LEN_W-1:0]  max_len;
    } dsfr_cfg_t;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] data;
        logic [POS_W-1:0]  pos;
        logic [LEN_W-1:0]  len;
        logic              empty;
        logic              last;
    } dsfr_item_t;

endpackage

// File: hdl/dsfr_ifs.sv
// received byte channel
interface dsfr_rx_if
    import dsfr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// message byte channel
interface dsfr_msg_if
    import dsfr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              message_kind;
    logic [BYTE_W-1:0] payload_byte;
    logic [POS_W-1:0]  byte_position;
    logic [LEN_W-1:0]  message_length;
    logic              empty_message;
    logic              last_of_message;

    modport source (
        output valid, output message_kind, output payload_byte,
        output byte_position, output message_length,
        output empty_message, output last_of_message,
        input ready
    );
    modport sink (
        input valid, input message_kind, input payload_byte,
        input byte_position, input message_length,
        input empty_message, input last_of_message,
        output ready
    );
endinterface

// File: hdl/dsfr_apb_regs.sv
module dsfr_apb_regs
    import dsfr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    output dsfr_cfg_t          cfg
);

    dsfr_cfg_t cfg_reg;
    dsfr_cfg_t cfg_next;
    reg_idx_t  reg_idx;
    logic      wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    // write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_HDR1:    cfg_next.hdr1    = pwdata[BYTE_W-1:0];
                REG_HDR2:    cfg_next.hdr2    = pwdata[BYTE_W-1:0];
                REG_HDR3:    cfg_next.hdr3    = pwdata[BYTE_W-1:0];
                REG_TRL1:    cfg_next.trl1    = pwdata[BYTE_W-1:0];
                REG_TRL2:    cfg_next.trl2    = pwdata[BYTE_W-1:0];
                REG_MAX_LEN: cfg_next.max_len = pwdata[LEN_W-1:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_idx)
            REG_HDR1:    prdata = DATA_W'(cfg_reg.hdr1);
            REG_HDR2:    prdata = DATA_W'(cfg_reg.hdr2);
            REG_HDR3:    prdata = DATA_W'(cfg_reg.hdr3);
            REG_TRL1:    prdata = DATA_W'(cfg_reg.trl1);
            REG_TRL2:    prdata = DATA_W'(cfg_reg.trl2);
            REG_MAX_LEN: prdata = DATA_W'(cfg_reg.max_len);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hdr1    <= HDR1_RST;
            cfg_reg.hdr2    <= HDR2_RST;
            cfg_reg.hdr3    <= HDR3_RST;
            cfg_reg.trl1    <= TRL1_RST;
            cfg_reg.trl2    <= TRL2_RST;
            cfg_reg.max_len <= MAX_LEN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: hdl/dual_mode_serial_frame_receiver_core.sv
// Serial frame receiver: takes one received byte per item and recognizes either
// a text line ended by CR LF or a binary frame (three header bytes, 16-bit
// big-endian length, payload, 8-bit additive checksum, two trailer bytes).
// Message bytes are kept in a single-port-write, registered-read buffer of
// BUFFER_DEPTH bytes. After a byte that completes no message the input stays
// ready. A byte that completes a message holds off the input while the
// buffer is read out: each byte is read into the registered read port in
// ST_LOAD and then held in the output register in ST_OUT until the sink
// takes it. An empty message goes straight to the output register.
module dual_mode_serial_frame_receiver_core
    import dsfr_pkg::*;
#(
    parameter int BUFFER_DEPTH = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    dsfr_rx_if.sink            rx,
    dsfr_msg_if.source         msg
);

    localparam int ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);

    typedef enum logic [3:0] {
        PH_OP1, PH_OP2, PH_OP3, PH_LEN1, PH_LEN2,
        PH_DATA, PH_CHECK, PH_END1, PH_END2
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE, ST_LOAD, ST_OUT
    } rd_state_t;

    dsfr_cfg_t cfg;

    dsfr_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // control state
    logic              bin_reg, bin_next;
    phase_t            phase_reg, phase_next;
    logic              line_reg, line_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic              len_hi_reg, len_hi_next;
    logic [LEN_W-1:0]  decl_reg, decl_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    rd_state_t         st_reg, st_next;
    logic [ADDR_W-1:0] rd_idx_reg, rd_idx_next;
    logic              kind_reg, kind_next;
    logic [CNT_W-1:0]  mlen_reg, mlen_next;
    dsfr_item_t        out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    // message buffer
    logic [BYTE_W-1:0] store_mem [BUFFER_DEPTH];
    logic [BYTE_W-1:0] rdata_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [BYTE_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    logic              in_acc;
    logic [BYTE_W-1:0] b;
    logic [LEN_W-1:0]  limit;
    logic              too_long;
    logic [CNT_W-1:0]  fill_inc;
    logic              data_done;

    assign in_acc = rx.valid && rx.ready;
    assign b      = rx.rx_byte;

    // effective payload limit and length checks
    assign limit = (cfg.max_len > LEN_W'(BUFFER_DEPTH)) ? LEN_W'(BUFFER_DEPTH) : cfg.max_len;
    assign too_long  = len_hi_reg || (BYTE_W'(limit) < b);
    assign fill_inc  = (fill_reg < CNT_W'(BUFFER_DEPTH)) ? fill_reg + CNT_W'(1) : fill_reg;
    assign data_done = (LEN_W'(fill_inc) >= decl_reg) || (fill_inc >= CNT_W'(BUFFER_DEPTH));

    // outputs
    assign rx.ready            = (st_reg == ST_IDLE);
    assign msg.valid           = out_valid_reg;
    assign msg.message_kind    = out_reg.kind;
    assign msg.payload_byte    = out_reg.data;
    assign msg.byte_position   = out_reg.pos;
    assign msg.message_length  = out_reg.len;
    assign msg.empty_message   = out_reg.empty;
    assign msg.last_of_message = out_reg.last;

    // parser and readout next state
    always_comb
    begin
        logic             store;
        logic             wrap;
        logic             hdr_done;
        logic             err;
        logic             emit;
        logic             emit_kind;
        logic [CNT_W-1:0] base;

        store     = 1'b0;
        wrap      = 1'b0;
        hdr_done  = 1'b0;
        err       = 1'b0;
        emit      = 1'b0;
        emit_kind = 1'b0;
        base      = fill_reg;

        bin_next       = bin_reg;
        phase_next     = phase_reg;
        line_next      = line_reg;
        sum_next       = sum_reg;
        len_hi_next    = len_hi_reg;
        decl_next      = decl_reg;
        fill_next      = fill_reg;
        st_next        = st_reg;
        rd_idx_next    = rd_idx_reg;
        kind_next      = kind_reg;
        mlen_next      = mlen_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        mem_we    = 1'b0;
        mem_waddr = fill_reg[ADDR_W-1:0];
        mem_wdata = b;
        mem_re    = 1'b0;
        mem_raddr = rd_idx_reg;

        if (in_acc)
        begin
            if (bin_reg)
            begin
                // binary frame phases
                unique case (phase_reg)
                    PH_LEN1:
                    begin
                        sum_next    = b;
                        len_hi_next = |b;
                        phase_next  = PH_LEN2;
                    end
                    PH_LEN2:
                    begin
                        sum_next  = sum_reg + b;
                        decl_next = b[LEN_W-1:0];
                        fill_next = '0;
                        if (too_long)
                        begin
                            phase_next = PH_OP1;
                            bin_next   = 1'b0;
                        end
                        else
                        begin
                            phase_next = (b == '0) ? PH_CHECK : PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        store    = 1'b1;
                        sum_next = sum_reg + b;
                        if (data_done)
                        begin
                            phase_next = PH_CHECK;
                        end
                    end
                    PH_CHECK:
                    begin
                        if (sum_reg == b)
                            phase_next = PH_END1;
                        else
                            err = 1'b1;
                    end
                    PH_END1:
                    begin
                        if (b == cfg.trl1)
                            phase_next = PH_END2;
                        else
                            err = 1'b1;
                    end
                    PH_END2:
                    begin
                        if (b == cfg.trl2)
                        begin
                            phase_next = PH_OP1;
                            bin_next   = 1'b0;
                            emit       = 1'b1;
                            emit_kind  = 1'b1;
                        end
                        else
                        begin
                            err = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_OP1;
                        bin_next   = 1'b0;
                    end
                endcase

                // frame error resyncs on the first header byte
                if (err)
                begin
                    phase_next = (b == cfg.hdr1) ? PH_OP2 : PH_OP1;
                    bin_next   = 1'b0;
                    fill_next  = '0;
                end
            end
            else
            begin
                // header watch
                unique case (phase_reg)
                    PH_OP2:
                    begin
                        if (b == cfg.hdr2)
                            phase_next = PH_OP3;
                        else if (b == cfg.hdr1)
                            phase_next = PH_OP2;
                        else
                            phase_next = PH_OP1;
                    end
                    PH_OP3:
                    begin
                        if (b == cfg.hdr3)
                        begin
                            phase_next = PH_LEN1;
                            bin_next   = 1'b1;
                            line_next  = 1'b0;
                            hdr_done   = 1'b1;
                        end
                        else
                        begin
                            phase_next = (b == cfg.hdr1) ? PH_OP2 : PH_OP1;
                        end
                    end
                    default:
                    begin
                        if (b == cfg.hdr1)
                        begin
                            phase_next = PH_OP2;
                            sum_next   = '0;
                        end
                        else
                        begin
                            phase_next = PH_OP1;
                        end
                    end
                endcase

                // line gatherer
                if (!hdr_done)
                begin
                    if (!line_reg)
                    begin
                        if (b == CR_BYTE)
                        begin
                            line_next = 1'b1;
                        end
                        else
                        begin
                            wrap  = (fill_reg >= CNT_W'(BUFFER_DEPTH - 1));
                            store = 1'b1;
                        end
                    end
                    else
                    begin
                        line_next = 1'b0;
                        if (b == LF_BYTE)
                        begin
                            emit = 1'b1;
                        end
                        else
                        begin
                            wrap  = 1'b1;
                            store = 1'b1;
                        end
                    end
                end
            end

            // buffer write
            if (store)
            begin
                base = wrap ? '0 : fill_reg;
                if (base < CNT_W'(BUFFER_DEPTH))
                begin
                    mem_we    = 1'b1;
                    mem_waddr = base[ADDR_W-1:0];
                    fill_next = base + CNT_W'(1);
                end
            end

            // message complete: start readout
            if (emit)
            begin
                fill_next   = '0;
                kind_next   = emit_kind;
                mlen_next   = fill_reg;
                rd_idx_next = '0;
                if (fill_reg == '0)
                begin
                    out_next.kind  = emit_kind;
                    out_next.data  = '0;
                    out_next.pos   = '0;
                    out_next.len   = '0;
                    out_next.empty = 1'b1;
                    out_next.last  = 1'b1;
                    out_valid_next = 1'b1;
                    st_next        = ST_OUT;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = '0;
                    st_next   = ST_LOAD;
                end
            end
        end

        // readout sequencer
        unique case (st_reg)
            ST_IDLE:
            begin
                st_next = st_next;
            end
            ST_LOAD:
            begin
                out_next.kind  = kind_reg;
                out_next.data  = rdata_reg;
                out_next.pos   = POS_W'(rd_idx_reg);
                out_next.len   = LEN_W'(mlen_reg);
                out_next.empty = 1'b0;
                out_next.last  = (CNT_W'(rd_idx_reg) + CNT_W'(1) == mlen_reg);
                out_valid_next = 1'b1;
                st_next        = ST_OUT;
            end
            ST_OUT:
            begin
                if (msg.ready)
                begin
                    out_valid_next = 1'b0;
                    if (out_reg.last)
                    begin
                        st_next = ST_IDLE;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + ADDR_W'(1);
                        mem_re      = 1'b1;
                        mem_raddr   = rd_idx_reg + ADDR_W'(1);
                        st_next     = ST_LOAD;
                    end
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_reg       <= 1'b0;
            phase_reg     <= PH_OP1;
            line_reg      <= 1'b0;
            sum_reg       <= '0;
            len_hi_reg    <= 1'b0;
            decl_reg      <= '0;
            fill_reg      <= '0;
            st_reg        <= ST_IDLE;
            rd_idx_reg    <= '0;
            kind_reg      <= 1'b0;
            mlen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bin_reg       <= bin_next;
            phase_reg     <= phase_next;
            line_reg      <= line_next;
            sum_reg       <= sum_next;
            len_hi_reg    <= len_hi_next;
            decl_reg      <= decl_next;
            fill_reg      <= fill_next;
            st_reg        <= st_next;
            rd_idx_reg    <= rd_idx_next;
            kind_reg      <= kind_next;
            mlen_reg      <= mlen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // message buffer, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= store_mem[mem_raddr];
        end
    end

`ifndef SYNTHESIS
    // input is held off while a message is read out
    assert property (@(posedge clk) disable iff (!rst_n) rx.ready |-> !msg.valid)
        else $error("input ready while an item is pending");

    // buffer is never written during readout
    assert property (@(posedge clk) disable iff (!rst_n) mem_we |-> st_reg == ST_IDLE)
        else $error("buffer write outside idle");

    // fill count stays within the buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(BUFFER_DEPTH))
        else $error("fill count beyond buffer depth");

    // binary mode only in frame phases after the header
    assert property (@(posedge clk) disable iff (!rst_n)
        bin_reg |-> !(phase_reg == PH_OP1 || phase_reg == PH_OP2 || phase_reg == PH_OP3))
        else $error("binary mode in a header phase");

    // taking the last item of a message reopens the input
    assert property (@(posedge clk) disable iff (!rst_n)
        msg.valid && msg.ready && msg.last_of_message |=> rx.ready)
        else $error("input not ready after last item");
`endif

endmodule

// File: verif/dsfr_checker.sv
// watches the apb port and both item channels, predicts every message byte
// and compares what the block hands out against it
module dsfr_checker
    import dsfr_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    input  logic               pready,
    dsfr_rx_if                 rx,
    dsfr_msg_if                msg,
    output int                 mismatch_count,
    output int                 results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [3:0] {
        WAIT_HDR1,
        WAIT_HDR2,
        WAIT_HDR3,
        LEN_HI,
        LEN_LO,
        PAYLOAD,
        CHECKSUM,
        TRAILER1,
        TRAILER2
    } frame_phase_t;

    // register copies
    logic [BYTE_W-1:0] cfg_hdr1, cfg_hdr2, cfg_hdr3, cfg_trl1, cfg_trl2;
    logic [LEN_W-1:0]  cfg_max_len;

    // receiver state
    logic              in_frame;
    frame_phase_t      phase;
    logic              line_cr_seen;
    logic [BYTE_W-1:0] frame_sum;
    logic [15:0]       frame_len;
    int                fill;
    logic [BYTE_W-1:0] msg_store [DEPTH];

    dsfr_item_t        msg_bytes_due [$];
    int                results_seen;

    task automatic report_mismatch(input string text);
        $display("MISMATCH at %0t: %s", $realtime, text);
        mismatch_count++;
    endtask

    task automatic check_field(input string field, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("result %0d %s: got %0d, want %0d",
                                      results_seen, field, got, want));
    endtask

    task automatic keep_byte(input logic [BYTE_W-1:0] b);
        if (fill < DEPTH)
        begin
            msg_store[fill] = b;
            fill++;
        end
    endtask

    // bad checksum or trailer: back to text, the byte may open a new header
    task automatic abort_frame(input logic [BYTE_W-1:0] b);
        if (b == cfg_hdr1)
            phase = WAIT_HDR2;
        else
            phase = WAIT_HDR1;
        in_frame = 1'b0;
        fill = 0;
    endtask

    // one expected item per stored byte, or a single empty marker
    task automatic queue_message_bytes(input logic kind);
        dsfr_item_t it;
        int n;
        n = fill;
        fill = 0;
        it.kind = kind;
        if (n == 0)
        begin
            it.data  = '0;
            it.pos   = '0;
            it.len   = '0;
            it.empty = 1'b1;
            it.last  = 1'b1;
            msg_bytes_due.push_back(it);
        end
        else
        begin
            for (int k = 0; k < n; k++)
            begin
                it.data  = msg_store[k];
                it.pos   = POS_W'(k);
                it.len   = LEN_W'(n);
                it.empty = 1'b0;
                it.last  = (k + 1 == n);
                msg_bytes_due.push_back(it);
            end
        end
    endtask

    task automatic take_rx_byte(input logic [BYTE_W-1:0] b);
        int  lim;
        logic header_done;
        header_done = 1'b0;
        if (in_frame)
        begin
            case (phase)
                LEN_HI:
                begin
                    frame_sum = b;
                    frame_len = {b, 8'h00};
                    phase = LEN_LO;
                end
                LEN_LO:
                begin
                    lim = (cfg_max_len > DEPTH) ? DEPTH : int'(cfg_max_len);
                    frame_sum = frame_sum + b;
                    frame_len = frame_len | {8'h00, b};
                    fill = 0;
                    if (frame_len > lim)
                    begin
                        phase = WAIT_HDR1;
                        in_frame = 1'b0;
                    end
                    else if (frame_len == 0)
                        phase = CHECKSUM;
                    else
                        phase = PAYLOAD;
                end
                PAYLOAD:
                begin
                    keep_byte(b);
                    frame_sum = frame_sum + b;
                    if (fill >= frame_len || fill >= DEPTH)
                        phase = CHECKSUM;
                end
                CHECKSUM:
                begin
                    if (frame_sum == b)
                        phase = TRAILER1;
                    else
                        abort_frame(b);
                end
                TRAILER1:
                begin
                    if (b == cfg_trl1)
                        phase = TRAILER2;
                    else
                        abort_frame(b);
                end
                TRAILER2:
                begin
                    if (b == cfg_trl2)
                    begin
                        phase = WAIT_HDR1;
                        in_frame = 1'b0;
                        queue_message_bytes(1'b1);
                    end
                    else
                        abort_frame(b);
                end
                default:
                begin
                    phase = WAIT_HDR1;
                    in_frame = 1'b0;
                end
            endcase
        end
        else
        begin
            // header watch runs beside the line gatherer
            case (phase)
                WAIT_HDR2:
                begin
                    if (b == cfg_hdr2)
                        phase = WAIT_HDR3;
                    else if (b == cfg_hdr1)
                        phase = WAIT_HDR2;
                    else
                        phase = WAIT_HDR1;
                end
                WAIT_HDR3:
                begin
                    if (b == cfg_hdr3)
                    begin
                        phase = LEN_HI;
                        in_frame = 1'b1;
                        line_cr_seen = 1'b0;
                        header_done = 1'b1;
                    end
                    else if (b == cfg_hdr1)
                        phase = WAIT_HDR2;
                    else
                        phase = WAIT_HDR1;
                end
                default:
                begin
                    if (b == cfg_hdr1)
                    begin
                        phase = WAIT_HDR2;
                        frame_sum = '0;
                    end
                    else
                        phase = WAIT_HDR1;
                end
            endcase

            // line gatherer, skipped on the byte that completes a header
            if (!header_done)
            begin
                if (!line_cr_seen)
                begin
                    if (b == CR_BYTE)
                        line_cr_seen = 1'b1;
                    else
                    begin
                        if (fill >= DEPTH - 1)
                            fill = 0;
                        keep_byte(b);
                    end
                end
                else
                begin
                    line_cr_seen = 1'b0;
                    if (b == LF_BYTE)
                        queue_message_bytes(1'b0);
                    else
                    begin
                        fill = 0;
                        keep_byte(b);
                    end
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        dsfr_item_t want;
        reg_idx_t   widx;
        if (!rst_n)
        begin
            cfg_hdr1      = HDR1_RST;
            cfg_hdr2      = HDR2_RST;
            cfg_hdr3      = HDR3_RST;
            cfg_trl1      = TRL1_RST;
            cfg_trl2      = TRL2_RST;
            cfg_max_len   = MAX_LEN_RST;
            in_frame      = 1'b0;
            phase         = WAIT_HDR1;
            line_cr_seen  = 1'b0;
            frame_sum     = '0;
            frame_len     = '0;
            fill          = 0;
            msg_bytes_due.delete();
            results_seen  = 0;
            mismatch_count = 0;
            results_due   = 0;
        end
        else
        begin
            // register writes
            if (psel && penable && pwrite && pready)
            begin
                widx = paddr[PADDR_W-1:2];
                case (widx)
                    REG_HDR1:    cfg_hdr1 = pwdata[BYTE_W-1:0];
                    REG_HDR2:    cfg_hdr2 = pwdata[BYTE_W-1:0];
                    REG_HDR3:    cfg_hdr3 = pwdata[BYTE_W-1:0];
                    REG_TRL1:    cfg_trl1 = pwdata[BYTE_W-1:0];
                    REG_TRL2:    cfg_trl2 = pwdata[BYTE_W-1:0];
                    REG_MAX_LEN: cfg_max_len = pwdata[LEN_W-1:0];
                    default:     ;
                endcase
            end

            // accepted input item
            if (rx.valid && rx.ready)
                take_rx_byte(rx.rx_byte);

            // accepted result item
            if (msg.valid && msg.ready)
            begin
                if (msg_bytes_due.size() == 0)
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              results_seen));
                else
                begin
                    want = msg_bytes_due.pop_front();
                    check_field("message_kind", int'(msg.message_kind), int'(want.kind));
                    check_field("payload_byte", int'(msg.payload_byte), int'(want.data));
                    check_field("byte_position", int'(msg.byte_position), int'(want.pos));
                    check_field("message_length", int'(msg.message_length),
                                int'(want.len));
                    check_field("empty_message", int'(msg.empty_message),
                                int'(want.empty));
                    check_field("last_of_message", int'(msg.last_of_message),
                                int'(want.last));
                end
                results_seen++;
            end
            results_due = msg_bytes_due.size();
        end
    end

endmodule

// File: verif/tb_dual_mode_serial_frame_receiver_core.sv
module tb_dual_mode_serial_frame_receiver_core;
    timeunit 1ns;
    timeprecision 1ps;

    import dsfr_pkg::*;

    localparam int DEPTH = 64;

    // frame shapes for the random part
    localparam int FRAME_CLEAN    = 0;
    localparam int FRAME_BAD_SUM  = 1;
    localparam int FRAME_RESYNC   = 2;
    localparam int FRAME_BAD_TRL1 = 3;
    localparam int FRAME_BAD_TRL2 = 4;

    localparam int PHASE_BUDGET  = 50;
    localparam int SETTLE_CYCLES = 2 * DEPTH + 30;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    dsfr_rx_if  rx_ch ();
    dsfr_msg_if msg_ch ();

    int mismatch_count;
    int results_due;
    int gap_pct;
    int stall_pct;
    int bytes_sent;

    // framing bytes currently programmed
    logic [BYTE_W-1:0] cur_hdr1, cur_hdr2, cur_hdr3, cur_trl1, cur_trl2;
    int                cur_max;

    dual_mode_serial_frame_receiver_core #(
        .BUFFER_DEPTH (DEPTH)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .rx      (rx_ch),
        .msg     (msg_ch)
    );

    dsfr_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .rx             (rx_ch),
        .msg            (msg_ch),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver back-pressure
    always @(negedge clk)
        msg_ch.ready <= ($urandom_range(0, 99) >= stall_pct);

    task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input logic [BYTE_W-1:0] h1, input logic [BYTE_W-1:0] h2,
                              input logic [BYTE_W-1:0] h3, input logic [BYTE_W-1:0] t1,
                              input logic [BYTE_W-1:0] t2, input int max_len);
        cur_hdr1 = h1;
        cur_hdr2 = h2;
        cur_hdr3 = h3;
        cur_trl1 = t1;
        cur_trl2 = t2;
        cur_max  = max_len;
        write_reg(REG_HDR1, DATA_W'(h1));
        write_reg(REG_HDR2, DATA_W'(h2));
        write_reg(REG_HDR3, DATA_W'(h3));
        write_reg(REG_TRL1, DATA_W'(t1));
        write_reg(REG_TRL2, DATA_W'(t2));
        write_reg(REG_MAX_LEN, DATA_W'(max_len));
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_rx_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            rx_ch.valid <= 1'b0;
            @(negedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (!rx_ch.ready)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_frame(input int len, input int shape);
        logic [BYTE_W-1:0] sum, b;
        int lim;
        lim = (cur_max > DEPTH) ? DEPTH : cur_max;
        send_rx_byte(cur_hdr1);
        send_rx_byte(cur_hdr2);
        send_rx_byte(cur_hdr3);
        send_rx_byte(len[15:8]);
        send_rx_byte(len[7:0]);
        // an oversized length ends the frame right here
        if (len <= lim)
        begin
            sum = len[15:8] + len[7:0];
            repeat (len)
            begin
                b = 8'($urandom_range(0, 255));
                sum = sum + b;
                send_rx_byte(b);
            end
            if (shape == FRAME_BAD_SUM)
                send_rx_byte(sum ^ 8'($urandom_range(1, 255)));
            else if (shape == FRAME_RESYNC)
            begin
                // checksum slot carries the first header byte, then an empty frame
                send_rx_byte(cur_hdr1);
                send_rx_byte(cur_hdr2);
                send_rx_byte(cur_hdr3);
                send_rx_byte(8'h00);
                send_rx_byte(8'h00);
                send_rx_byte(8'h00);
            end
            else
                send_rx_byte(sum);
            if (shape == FRAME_BAD_TRL1)
                send_rx_byte(cur_trl1 ^ 8'($urandom_range(1, 255)));
            else
                send_rx_byte(cur_trl1);
            if (shape == FRAME_BAD_TRL2)
                send_rx_byte(cur_trl2 ^ 8'($urandom_range(1, 255)));
            else
                send_rx_byte(cur_trl2);
        end
    endtask

    task automatic run_random_traffic(input int budget);
        int first, pick, sel, len, lim;
        logic [BYTE_W-1:0] b;
        first = bytes_sent;
        lim = (cur_max > DEPTH) ? DEPTH : cur_max;
        while (bytes_sent - first < budget)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                // text line, now and then long enough to wrap
                if ($urandom_range(0, 19) == 0)
                    len = $urandom_range(DEPTH - 4, DEPTH + 6);
                else
                    len = $urandom_range(0, 8);
                repeat (len)
                begin
                    b = 8'($urandom_range(0, 255));
                    if (b == CR_BYTE)
                        b = 8'h20;
                    send_rx_byte(b);
                end
                send_rx_byte(CR_BYTE);
                send_rx_byte(LF_BYTE);
            end
            else if (pick < 92)
            begin
                // binary frame, mostly short and in range
                sel = $urandom_range(0, 99);
                if (sel < 70)
                    len = $urandom_range(0, (lim < 6) ? lim : 6);
                else if (sel < 85)
                    len = $urandom_range(0, lim);
                else if (sel < 95)
                    len = $urandom_range(lim + 1, 255);
                else
                    len = $urandom_range(256, 65535);
                if (pick < 80)
                    send_frame(len, FRAME_CLEAN);
                else
                    send_frame(len, $urandom_range(FRAME_BAD_SUM, FRAME_BAD_TRL2));
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                // cr not followed by lf
                b = 8'($urandom_range(0, 255));
                if (b == LF_BYTE)
                    b = 8'h00;
                send_rx_byte(CR_BYTE);
                send_rx_byte(b);
            end
            else
            begin
                repeat ($urandom_range(1, 5))
                    send_rx_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // hold the sender until every result is out and the block has settled
    task automatic drain;
        rx_ch.valid <= 1'b0;
        while (results_due != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    initial
    begin : stimulus
        logic [BYTE_W-1:0] opening [$];
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        rx_ch.valid    = 1'b0;
        rx_ch.rx_byte  = '0;
        msg_ch.ready   = 1'b0;
        gap_pct        = 0;
        stall_pct      = 0;
        bytes_sent     = 0;
        cur_hdr1       = HDR1_RST;
        cur_hdr2       = HDR2_RST;
        cur_hdr3       = HDR3_RST;
        cur_trl1       = TRL1_RST;
        cur_trl2       = TRL2_RST;
        cur_max        = int'(MAX_LEN_RST);

        // empty line, extreme bytes with a broken line end, empty frame,
        // then a frame whose length is too large
        opening = '{CR_BYTE, LF_BYTE,
                    8'h00, 8'hFF, CR_BYTE, 8'h41, CR_BYTE, LF_BYTE,
                    HDR1_RST, HDR2_RST, HDR3_RST, 8'h00, 8'h00, 8'h00,
                    TRL1_RST, TRL2_RST,
                    HDR1_RST, HDR2_RST, HDR3_RST, 8'h00, 8'h41};

        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset values, no idling
        foreach (opening[i])
            send_rx_byte(opening[i]);
        run_random_traffic(PHASE_BUDGET);
        drain();

        // header and trailer bytes at the extremes and CR, zero length limit, sender idles
        set_config(8'h00, 8'hFF, CR_BYTE, 8'hFF, 8'h00, 0);
        gap_pct = 76;
        stall_pct = 0;
        run_random_traffic(PHASE_BUDGET);
        drain();

        // repeated header byte, swapped trailers, receiver stalls
        set_config(8'h41, 8'h41, 8'h41, LF_BYTE, CR_BYTE, 1);
        gap_pct = 0;
        stall_pct = 76;
        run_random_traffic(PHASE_BUDGET);
        drain();

        // limit above the buffer depth, both sides idle
        set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 127);
        gap_pct = 28;
        stall_pct = 28;
        run_random_traffic(PHASE_BUDGET);
        drain();

        // full depth limit, no idling
        set_config(8'hFF, 8'h00, LF_BYTE, CR_BYTE, LF_BYTE, DEPTH);
        gap_pct = 0;
        stall_pct = 0;
        run_random_traffic(PHASE_BUDGET);
        drain();

        // random framing bytes and limit, sender idles
        set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), $urandom_range(2, DEPTH));
        gap_pct = 76;
        stall_pct = 0;
        run_random_traffic(PHASE_BUDGET);
        drain();

        // back to reset values, receiver stalls
        set_config(HDR1_RST, HDR2_RST, HDR3_RST, TRL1_RST, TRL2_RST, int'(MAX_LEN_RST));
        gap_pct = 0;
        stall_pct = 76;
        run_random_traffic(PHASE_BUDGET);
        drain();

        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // run limit
    initial
    begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
